// ===== rtl/lpmr_pkg.sv =====
// shared types and codes for the length-prefixed message ring
package lpmr_pkg;

   // request actions
   localparam logic [2:0] ACT_WR_START = 3'd0;
   localparam logic [2:0] ACT_WR_BYTE  = 3'd1;
   localparam logic [2:0] ACT_READ     = 3'd2;
   localparam logic [2:0] ACT_PEEK     = 3'd3;
   localparam logic [2:0] ACT_DISCARD  = 3'd4;
   localparam logic [2:0] ACT_CHECK    = 3'd5;

   // response status codes
   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_FULL    = 3'd1;
   localparam logic [2:0] STAT_EMPTY   = 3'd2;
   localparam logic [2:0] STAT_SMALL   = 3'd3;
   localparam logic [2:0] STAT_INVALID = 3'd4;

   // ring geometry
   localparam int HDR_BYTES    = 4;
   localparam int MIN_CAPACITY = 64;
   localparam int CSR_W        = 13;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_HDR_WR,
      S_HDR_RD,
      S_DECIDE,
      S_STREAM,
      S_RESP
   } state_type;

   // one response from the sequencer to the output register
   typedef struct packed {
      logic       load;
      logic [2:0] status;
      logic [7:0] data;
      logic [5:0] length;
      logic       last;
   } rsp_type;

endpackage

// ===== rtl/lpmr_ram.sv =====
// generic simple dual-port ram with registered read data
module lpmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lpmr_ctrl.sv =====
// sequencer: ring pointers, header handling and byte streaming over the ring ram
module lpmr_ctrl #(
   parameter int RING_BYTES  = 4096,
   parameter int MAX_MSG_LEN = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_clear,
   input  logic [$clog2(RING_BYTES+1)-1:0]   capacity,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_action,
   input  logic [5:0]                        req_msg_length,
   input  logic [7:0]                        req_data_byte,
   input  logic [5:0]                        req_max_length,
   input  logic                              out_free,
   output lpmr_pkg::rsp_type                 rsp,
   output logic                              ram_wr_en,
   output logic [$clog2(RING_BYTES)-1:0]     ram_wr_addr,
   output logic [7:0]                        ram_wr_data,
   output logic                              ram_rd_en,
   output logic [$clog2(RING_BYTES)-1:0]     ram_rd_addr,
   input  logic [7:0]                        ram_rd_data
);

   localparam int PTR_W = $clog2(RING_BYTES);
   localparam int CAP_W = $clog2(RING_BYTES + 1);
   localparam int SUM_W = CAP_W + 1;
   localparam int LEN_W = (MAX_MSG_LEN < 2) ? 1 : $clog2(MAX_MSG_LEN + 1);
   localparam int OFF_W = $clog2(MAX_MSG_LEN + lpmr_pkg::HDR_BYTES + 1);
   localparam logic [OFF_W-1:0] HDR_OFF = OFF_W'(lpmr_pkg::HDR_BYTES);
   localparam logic [OFF_W-1:0] LAST_HDR_OFF = OFF_W'(lpmr_pkg::HDR_BYTES - 1);

   lpmr_pkg::state_type state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic             open_ff, open_in;
   logic [LEN_W-1:0] open_len_ff, open_len_in;
   logic [OFF_W-1:0] cnt_ff, cnt_in;
   logic [2:0]       act_ff, act_in;
   logic [5:0]       maxlen_ff, maxlen_in;
   logic [5:0]       mlen_ff, mlen_in;
   logic [7:0]       lo_ff, lo_in;
   logic             hi_nz_ff, hi_nz_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [2:0]       pst_ff, pst_in;
   logic [5:0]       plen_ff, plen_in;

   logic             accept;
   logic [CAP_W-1:0] free_raw;
   logic [CAP_W-1:0] free_bytes;
   logic [SUM_W-1:0] need_bytes;
   logic             fits;
   logic             mlen_over;
   logic [LEN_W-1:0] len_c;

   // position plus offset, wrapped at the capacity
   function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] pos,
                                                 input logic [OFF_W-1:0] n,
                                                 input logic [CAP_W-1:0] cap);
      logic [SUM_W-1:0] s;
      s = SUM_W'(pos) + SUM_W'(n);
      if (s >= SUM_W'(cap)) begin
         s = s - SUM_W'(cap);
      end
      return PTR_W'(s);
   endfunction

   // free space and fit test against the committed head
   always_comb begin
      if (tail_ff >= head_ff) begin
         free_raw = CAP_W'(tail_ff) - CAP_W'(head_ff);
      end else begin
         free_raw = capacity - CAP_W'(head_ff) + CAP_W'(tail_ff);
      end
      free_bytes = (free_raw == '0) ? capacity : free_raw;
      need_bytes = SUM_W'(req_msg_length) + SUM_W'(lpmr_pkg::HDR_BYTES + 1);
      fits       = SUM_W'(free_bytes) >= need_bytes;
      mlen_over  = 32'(req_msg_length) > MAX_MSG_LEN;
   end

   // stored length from the header bytes, saturated
   always_comb begin
      if (hi_nz_ff || (32'(lo_ff) > MAX_MSG_LEN)) begin
         len_c = LEN_W'(MAX_MSG_LEN);
      end else begin
         len_c = LEN_W'(lo_ff);
      end
   end

   assign req_stall = !((state_ff == lpmr_pkg::S_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   // next state and outputs
   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      wp_in       = wp_ff;
      rem_in      = rem_ff;
      open_in     = open_ff;
      open_len_in = open_len_ff;
      cnt_in      = cnt_ff;
      act_in      = act_ff;
      maxlen_in   = maxlen_ff;
      mlen_in     = mlen_ff;
      lo_in       = lo_ff;
      hi_nz_in    = hi_nz_ff;
      len_in      = len_ff;
      pst_in      = pst_ff;
      plen_in     = plen_ff;

      rsp         = '0;
      rsp.last    = 1'b1;
      ram_wr_en   = 1'b0;
      ram_wr_addr = head_ff;
      ram_wr_data = 8'd0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = tail_ff;

      case (state_ff)
         lpmr_pkg::S_IDLE: begin
            if (accept) begin
               case (req_action)
                  lpmr_pkg::ACT_WR_START: begin
                     if ((req_msg_length == 6'd0) || mlen_over) begin
                        rsp.load   = 1'b1;
                        rsp.status = lpmr_pkg::STAT_INVALID;
                     end else if (!fits) begin
                        rsp.load   = 1'b1;
                        rsp.status = lpmr_pkg::STAT_FULL;
                     end else begin
                        // low header byte now, the rest in S_HDR_WR
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = head_ff;
                        ram_wr_data = 8'(req_msg_length);
                        mlen_in     = req_msg_length;
                        cnt_in      = OFF_W'(1);
                        state_in    = lpmr_pkg::S_HDR_WR;
                     end
                  end
                  lpmr_pkg::ACT_WR_BYTE: begin
                     rsp.load = 1'b1;
                     if (!open_ff) begin
                        rsp.status = lpmr_pkg::STAT_INVALID;
                     end else begin
                        rsp.status  = lpmr_pkg::STAT_OK;
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = wp_ff;
                        ram_wr_data = req_data_byte;
                        wp_in       = ring_add(wp_ff, OFF_W'(1), capacity);
                        rem_in      = rem_ff - LEN_W'(1);
                        // last byte in: commit the message
                        if (rem_ff == LEN_W'(1)) begin
                           head_in = ring_add(head_ff, OFF_W'(open_len_ff) + HDR_OFF,
                                              capacity);
                           open_in = 1'b0;
                        end
                     end
                  end
                  lpmr_pkg::ACT_READ, lpmr_pkg::ACT_PEEK, lpmr_pkg::ACT_DISCARD: begin
                     if (tail_ff == head_ff) begin
                        rsp.load   = 1'b1;
                        rsp.status = (req_action == lpmr_pkg::ACT_DISCARD) ?
                                     lpmr_pkg::STAT_OK : lpmr_pkg::STAT_EMPTY;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = tail_ff;
                        cnt_in      = OFF_W'(1);
                        act_in      = req_action;
                        maxlen_in   = req_max_length;
                        hi_nz_in    = 1'b0;
                        state_in    = lpmr_pkg::S_HDR_RD;
                     end
                  end
                  lpmr_pkg::ACT_CHECK: begin
                     rsp.load = 1'b1;
                     if (mlen_over) begin
                        rsp.status = lpmr_pkg::STAT_INVALID;
                     end else if (!fits) begin
                        rsp.status = lpmr_pkg::STAT_FULL;
                     end else begin
                        rsp.status = lpmr_pkg::STAT_OK;
                     end
                  end
                  default: begin
                     rsp.load   = 1'b1;
                     rsp.status = lpmr_pkg::STAT_INVALID;
                  end
               endcase
            end
         end

         // upper header bytes are zero
         lpmr_pkg::S_HDR_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ring_add(head_ff, cnt_ff, capacity);
            ram_wr_data = 8'd0;
            if (cnt_ff == LAST_HDR_OFF) begin
               wp_in       = ring_add(head_ff, HDR_OFF, capacity);
               rem_in      = LEN_W'(mlen_ff);
               open_len_in = LEN_W'(mlen_ff);
               open_in     = 1'b1;
               pst_in      = lpmr_pkg::STAT_OK;
               plen_in     = 6'd0;
               state_in    = lpmr_pkg::S_RESP;
            end else begin
               cnt_in = cnt_ff + OFF_W'(1);
            end
         end

         // collect header bytes, one read in flight
         lpmr_pkg::S_HDR_RD: begin
            if (cnt_ff == OFF_W'(1)) begin
               lo_in = ram_rd_data;
            end else if (ram_rd_data != 8'd0) begin
               hi_nz_in = 1'b1;
            end
            if (cnt_ff < HDR_OFF) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ring_add(tail_ff, cnt_ff, capacity);
               cnt_in      = cnt_ff + OFF_W'(1);
            end else begin
               state_in = lpmr_pkg::S_DECIDE;
            end
         end

         lpmr_pkg::S_DECIDE: begin
            len_in = len_c;
            if (act_ff == lpmr_pkg::ACT_DISCARD) begin
               tail_in  = ring_add(tail_ff, OFF_W'(len_c) + HDR_OFF, capacity);
               pst_in   = lpmr_pkg::STAT_OK;
               plen_in  = 6'd0;
               state_in = lpmr_pkg::S_RESP;
            end else if (8'(len_c) > 8'(maxlen_ff)) begin
               pst_in   = lpmr_pkg::STAT_SMALL;
               plen_in  = 6'(len_c);
               state_in = lpmr_pkg::S_RESP;
            end else if (len_c == '0) begin
               // empty message: a read skips only the header
               if (act_ff == lpmr_pkg::ACT_READ) begin
                  tail_in = ring_add(tail_ff, HDR_OFF, capacity);
               end
               pst_in   = lpmr_pkg::STAT_OK;
               plen_in  = 6'd0;
               state_in = lpmr_pkg::S_RESP;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ring_add(tail_ff, HDR_OFF, capacity);
               cnt_in      = HDR_OFF + OFF_W'(1);
               state_in    = lpmr_pkg::S_STREAM;
            end
         end

         // one data byte per cycle while the output drains
         lpmr_pkg::S_STREAM: begin
            if (out_free) begin
               rsp.load   = 1'b1;
               rsp.status = lpmr_pkg::STAT_OK;
               rsp.data   = ram_rd_data;
               rsp.length = 6'(len_ff);
               rsp.last   = (cnt_ff == OFF_W'(len_ff) + HDR_OFF);
               if (cnt_ff == OFF_W'(len_ff) + HDR_OFF) begin
                  if (act_ff == lpmr_pkg::ACT_READ) begin
                     tail_in = ring_add(tail_ff, OFF_W'(len_ff) + HDR_OFF, capacity);
                  end
                  state_in = lpmr_pkg::S_IDLE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = ring_add(tail_ff, cnt_ff, capacity);
                  cnt_in      = cnt_ff + OFF_W'(1);
               end
            end
         end

         lpmr_pkg::S_RESP: begin
            if (out_free) begin
               rsp.load   = 1'b1;
               rsp.status = pst_ff;
               rsp.length = plen_ff;
               state_in   = lpmr_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = lpmr_pkg::S_IDLE;
         end
      endcase

      // capacity write empties the ring
      if (csr_clear) begin
         head_in     = '0;
         tail_in     = '0;
         wp_in       = '0;
         rem_in      = '0;
         open_in     = 1'b0;
         open_len_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lpmr_pkg::S_IDLE;
         head_ff     <= '0;
         tail_ff     <= '0;
         wp_ff       <= '0;
         rem_ff      <= '0;
         open_ff     <= 1'b0;
         open_len_ff <= '0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         wp_ff       <= wp_in;
         rem_ff      <= rem_in;
         open_ff     <= open_in;
         open_len_ff <= open_len_in;
      end
   end

   // working registers of the current request
   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      act_ff    <= act_in;
      maxlen_ff <= maxlen_in;
      mlen_ff   <= mlen_in;
      lo_ff     <= lo_in;
      hi_nz_ff  <= hi_nz_in;
      len_ff    <= len_in;
      pst_ff    <= pst_in;
      plen_ff   <= plen_in;
   end

endmodule

// ===== rtl/length_prefixed_message_ring.sv =====
// top level of the length-prefixed message ring
// A byte ring of up to RING_BYTES bytes holding messages of 1 to MAX_MSG_LEN bytes, each
// behind a 4-byte little-endian length header. Write byte, check fit, and any request
// answered without touching the ring respond straight from the idle state. Write start
// writes the header bytes one after another, as the header goes through the single write
// port of the ring ram, then responds. Read and peek fetch the header, decide, then stream
// one data byte per cycle while the response side keeps up; discard and a too-small answer
// respond after deciding. A capacity write (clamped to 64..RING_BYTES) empties the ring;
// it is meant for an idle block. The ring ram needs no clearing pass: only written bytes
// are ever read.
module length_prefixed_message_ring #(
   parameter int RING_BYTES  = 4096,
   parameter int MAX_MSG_LEN = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [5:0]  req_msg_length,
   input  logic [7:0]  req_data_byte,
   input  logic [5:0]  req_max_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_data_out,
   output logic [5:0]  rsp_length_out,
   output logic        rsp_last_out,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data
);

   localparam int PTR_W   = $clog2(RING_BYTES);
   localparam int CAP_W   = $clog2(RING_BYTES + 1);
   localparam int CAP_RST = (RING_BYTES < 4096) ? RING_BYTES : 4096;

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       status_ff;
   logic [7:0]       data_ff;
   logic [5:0]       length_ff;
   logic             last_ff;

   logic              out_free;
   lpmr_pkg::rsp_type rsp;
   logic              ram_wr_en;
   logic [PTR_W-1:0]  ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic              ram_rd_en;
   logic [PTR_W-1:0]  ram_rd_addr;
   logic [7:0]        ram_rd_data;
   logic [31:0]       csr_val;

   // capacity clamp
   always_comb begin
      csr_val = 32'(csr_wr_data);
      capacity_in = capacity_ff;
      if (csr_wr_en) begin
         if (csr_val < 32'(lpmr_pkg::MIN_CAPACITY)) begin
            capacity_in = CAP_W'(lpmr_pkg::MIN_CAPACITY);
         end else if (csr_val > 32'(RING_BYTES)) begin
            capacity_in = CAP_W'(RING_BYTES);
         end else begin
            capacity_in = CAP_W'(csr_val);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(CAP_RST);
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // output register, free when empty or draining this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp.load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp.load) begin
         status_ff <= rsp.status;
         data_ff   <= rsp.data;
         length_ff <= rsp.length;
         last_ff   <= rsp.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_data_out   = data_ff;
   assign rsp_length_out = length_ff;
   assign rsp_last_out   = last_ff;

   // sequencer
   lpmr_ctrl #(
      .RING_BYTES  (RING_BYTES),
      .MAX_MSG_LEN (MAX_MSG_LEN)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_clear      (csr_wr_en),
      .capacity       (capacity_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_msg_length (req_msg_length),
      .req_data_byte  (req_data_byte),
      .req_max_length (req_max_length),
      .out_free       (out_free),
      .rsp            (rsp),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data)
   );

   // ring storage
   lpmr_ram #(
      .WIDTH (8),
      .DEPTH (RING_BYTES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== tb/tb_length_prefixed_message_ring.sv =====
// testbench for the length-prefixed message ring: queued requests, a running ring model, reply checks
module tb_length_prefixed_message_ring;
   import lpmr_pkg::*;

   localparam int RING_BYTES    = 4096;
   localparam int MAX_MSG_LEN   = 32;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_ITEMS   = 36;

   // action codes the block does not know
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [2:0] action;
      logic [5:0] msg_length;
      logic [7:0] data_byte;
      logic [5:0] max_length;
   } request_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] data;
      logic [5:0] length;
      logic       last;
   } reply_type;

   // clock, reset and block ports
   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action     = ACT_WR_START;
   logic [5:0]  req_msg_length = '0;
   logic [7:0]  req_data_byte  = '0;
   logic [5:0]  req_max_length = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_data_out;
   logic [5:0]  rsp_length_out;
   logic        rsp_last_out;
   logic        csr_wr_en      = 1'b0;
   logic [12:0] csr_wr_data    = '0;

   // ring model state
   logic [7:0]  ring_mem [RING_BYTES];
   int unsigned ring_cap   = RING_BYTES;
   int unsigned head       = 0;
   int unsigned tail       = 0;
   int unsigned wptr       = 0;
   int unsigned bytes_left = 0;
   int unsigned open_len   = 0;
   bit          open_flag  = 1'b0;

   // request and reply bookkeeping
   request_type pending_requests [$];
   reply_type   due_replies [$];
   request_type outgoing;
   int unsigned issued_count   = 0;
   int unsigned taken_count    = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          quiet_cycles   = 0;
   bit          req_taken      = 1'b0;
   bit          fault_seen     = 1'b0;

   length_prefixed_message_ring #(
      .RING_BYTES  (RING_BYTES),
      .MAX_MSG_LEN (MAX_MSG_LEN)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_msg_length (req_msg_length),
      .req_data_byte  (req_data_byte),
      .req_max_length (req_max_length),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_data_out   (rsp_data_out),
      .rsp_length_out (rsp_length_out),
      .rsp_last_out   (rsp_last_out),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // free-running clock
   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned ring_wrap(int unsigned pos, int unsigned n);
      return (pos + n) % ring_cap;
   endfunction

   // free bytes between head and tail, a full lap when they meet
   function automatic int unsigned free_bytes();
      int unsigned f;
      f = (tail + ring_cap - head) % ring_cap;
      return (f == 0) ? ring_cap : f;
   endfunction

   // little-endian header at the tail, saturated to the largest message
   function automatic int unsigned head_length();
      int unsigned v;
      int unsigned i;
      v = 0;
      for (i = 0; i < HDR_BYTES; i++) begin
         v = v | ({24'd0, ring_mem[ring_wrap(tail, i)]} << (8 * i));
      end
      return (v > MAX_MSG_LEN) ? MAX_MSG_LEN : v;
   endfunction

   function automatic void clear_pointers();
      head       = 0;
      tail       = 0;
      wptr       = 0;
      bytes_left = 0;
      open_len   = 0;
      open_flag  = 1'b0;
   endfunction

   // capacity write clamps and empties the ring
   function automatic void ring_configure(logic [12:0] value);
      if (value < MIN_CAPACITY) begin
         ring_cap = MIN_CAPACITY;
      end else if (value > RING_BYTES) begin
         ring_cap = RING_BYTES;
      end else begin
         ring_cap = 32'(value);
      end
      clear_pointers();
   endfunction

   function automatic void add_reply(logic [2:0] st, logic [7:0] d, logic [5:0] l, logic lst);
      due_replies.push_back({st, d, l, lst});
   endfunction

   // apply one accepted request to the ring and queue the replies it causes
   function automatic void ring_apply(request_type r);
      int unsigned mlen;
      int unsigned len;
      int unsigned i;
      mlen = 32'(r.msg_length);
      case (r.action)
         ACT_WR_START: begin
            if (mlen == 0 || mlen > MAX_MSG_LEN) begin
               add_reply(STAT_INVALID, 8'd0, 6'd0, 1'b1);
            end else if (free_bytes() < mlen + HDR_BYTES + 1) begin
               add_reply(STAT_FULL, 8'd0, 6'd0, 1'b1);
            end else begin
               for (i = 0; i < HDR_BYTES; i++) begin
                  ring_mem[ring_wrap(head, i)] = 8'(mlen >> (8 * i));
               end
               wptr       = ring_wrap(head, HDR_BYTES);
               bytes_left = mlen;
               open_len   = mlen;
               open_flag  = 1'b1;
               add_reply(STAT_OK, 8'd0, 6'd0, 1'b1);
            end
         end
         ACT_WR_BYTE: begin
            if (!open_flag) begin
               add_reply(STAT_INVALID, 8'd0, 6'd0, 1'b1);
            end else begin
               ring_mem[wptr] = r.data_byte;
               wptr           = ring_wrap(wptr, 1);
               bytes_left     = bytes_left - 1;
               // last byte in: message becomes visible
               if (bytes_left == 0) begin
                  head      = ring_wrap(head, HDR_BYTES + open_len);
                  open_flag = 1'b0;
               end
               add_reply(STAT_OK, 8'd0, 6'd0, 1'b1);
            end
         end
         ACT_READ, ACT_PEEK: begin
            if (tail == head) begin
               add_reply(STAT_EMPTY, 8'd0, 6'd0, 1'b1);
            end else begin
               len = head_length();
               if (len > r.max_length) begin
                  add_reply(STAT_SMALL, 8'd0, 6'(len), 1'b1);
               end else if (len == 0) begin
                  if (r.action == ACT_READ) begin
                     tail = ring_wrap(tail, HDR_BYTES);
                  end
                  add_reply(STAT_OK, 8'd0, 6'd0, 1'b1);
               end else begin
                  for (i = 0; i < len; i++) begin
                     add_reply(STAT_OK, ring_mem[ring_wrap(tail, HDR_BYTES + i)], 6'(len),
                               (i + 1 == len));
                  end
                  if (r.action == ACT_READ) begin
                     tail = ring_wrap(tail, HDR_BYTES + len);
                  end
               end
            end
         end
         ACT_DISCARD: begin
            if (tail != head) begin
               tail = ring_wrap(tail, HDR_BYTES + head_length());
            end
            add_reply(STAT_OK, 8'd0, 6'd0, 1'b1);
         end
         ACT_CHECK: begin
            if (mlen > MAX_MSG_LEN) begin
               add_reply(STAT_INVALID, 8'd0, 6'd0, 1'b1);
            end else if (free_bytes() < mlen + HDR_BYTES + 1) begin
               add_reply(STAT_FULL, 8'd0, 6'd0, 1'b1);
            end else begin
               add_reply(STAT_OK, 8'd0, 6'd0, 1'b1);
            end
         end
         default: begin
            add_reply(STAT_INVALID, 8'd0, 6'd0, 1'b1);
         end
      endcase
   endfunction

   // compare one reply with the oldest one awaited
   task automatic reply_check();
      reply_type want;
      if (due_replies.size() == 0) begin
         $display("%0t: reply with none awaited: status %0d data %0h length %0d last %0b",
                  $time, rsp_status, rsp_data_out, rsp_length_out, rsp_last_out);
         fault_seen = 1'b1;
      end else begin
         want = due_replies.pop_front();
         if (rsp_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
            fault_seen = 1'b1;
         end
         if (rsp_data_out !== want.data) begin
            $display("%0t: data_out expected %0h actual %0h", $time, want.data, rsp_data_out);
            fault_seen = 1'b1;
         end
         if (rsp_length_out !== want.length) begin
            $display("%0t: length_out expected %0d actual %0d",
                     $time, want.length, rsp_length_out);
            fault_seen = 1'b1;
         end
         if (rsp_last_out !== want.last) begin
            $display("%0t: last_out expected %0b actual %0b", $time, want.last, rsp_last_out);
            fault_seen = 1'b1;
         end
      end
   endtask

   // sampling at the rising edge: model update, reply checks, watchdog
   always @(posedge clock) begin
      if (reset) begin
         req_taken    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (csr_wr_en) begin
            ring_configure(csr_wr_data);
         end
         if (req_valid && !req_stall) begin
            ring_apply({req_action, req_msg_length, req_data_byte, req_max_length});
            taken_count = taken_count + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            reply_check();
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("** length_prefixed_message_ring: FAILED **");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // request driver and reply stall, changing at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if (!req_valid || req_taken) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               outgoing = pending_requests.pop_front();
               req_action     <= outgoing.action;
               req_msg_length <= outgoing.msg_length;
               req_data_byte  <= outgoing.data_byte;
               req_max_length <= outgoing.max_length;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void queue_req(logic [2:0] a, logic [5:0] ml, logic [7:0] db,
                                     logic [5:0] mx);
      pending_requests.push_back({a, ml, db, mx});
      issued_count = issued_count + 1;
   endfunction

   // wait until every request is taken and every reply is in, then let the block settle
   task automatic wait_quiet();
      do @(negedge clock);
      while (taken_count != issued_count || due_replies.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // mostly whole messages with random content, with reads, peeks, discards and noise
   task automatic queue_random(int count);
      int made;
      int pick;
      int len;
      int cut;
      int i;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            // whole message, mostly short
            pick = $urandom_range(99);
            if (pick < 60) begin
               len = $urandom_range(8, 1);
            end else if (pick < 90) begin
               len = $urandom_range(31, 9);
            end else begin
               len = MAX_MSG_LEN;
            end
            queue_req(ACT_WR_START, 6'(len), 8'($urandom), 6'($urandom));
            for (i = 0; i < len; i++) begin
               queue_req(ACT_WR_BYTE, 6'($urandom), 8'($urandom), 6'($urandom));
            end
            made = made + len + 1;
         end else if (pick < 52) begin
            // message cut short, left open for the next start to abandon
            len = $urandom_range(MAX_MSG_LEN, 2);
            cut = $urandom_range(len - 1, 0);
            queue_req(ACT_WR_START, 6'(len), 8'($urandom), 6'($urandom));
            for (i = 0; i < cut; i++) begin
               queue_req(ACT_WR_BYTE, 6'($urandom), 8'($urandom), 6'($urandom));
            end
            made = made + cut + 1;
         end else if (pick < 80) begin
            // read or peek, buffer usually large enough
            len = ($urandom_range(3) != 0) ? $urandom_range(63, 32) : $urandom_range(63);
            queue_req((pick < 72) ? ACT_READ : ACT_PEEK, 6'($urandom), 8'($urandom),
                      6'(len));
            made = made + 1;
         end else if (pick < 86) begin
            queue_req(ACT_DISCARD, 6'($urandom), 8'($urandom), 6'($urandom));
            made = made + 1;
         end else if (pick < 92) begin
            queue_req(ACT_CHECK, 6'($urandom_range(63)), 8'($urandom), 6'($urandom));
            made = made + 1;
         end else begin
            queue_req(3'($urandom_range(7)), 6'($urandom), 8'($urandom), 6'($urandom));
            made = made + 1;
         end
      end
   endtask

   // stimulus: reset, directed requests, then random phases over capacities and idling
   initial begin : stimulus
      logic [12:0] capacity_list [PHASE_COUNT];
      int p;
      capacity_list = '{13'd0, 13'd8191, 13'd100, 13'd64, 13'd37, 13'd4096, 13'd257, 13'd64};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty ring
      queue_req(ACT_READ, 6'd0, 8'd0, 6'd63);
      queue_req(ACT_PEEK, 6'd63, 8'hFF, 6'd0);
      queue_req(ACT_DISCARD, 6'd0, 8'd0, 6'd0);
      queue_req(ACT_WR_BYTE, 6'd0, 8'hFF, 6'd0);
      // bad lengths, check fit and unknown actions
      queue_req(ACT_WR_START, 6'd0, 8'd0, 6'd0);
      queue_req(ACT_WR_START, 6'd33, 8'd0, 6'd0);
      queue_req(ACT_WR_START, 6'd63, 8'd0, 6'd0);
      queue_req(ACT_CHECK, 6'd0, 8'd0, 6'd0);
      queue_req(ACT_CHECK, 6'd32, 8'd0, 6'd0);
      queue_req(ACT_CHECK, 6'd63, 8'd0, 6'd0);
      queue_req(ACT_SPARE_6, 6'd1, 8'd1, 6'd1);
      queue_req(ACT_SPARE_7, 6'd63, 8'hFF, 6'd63);
      // one-byte message
      queue_req(ACT_WR_START, 6'd1, 8'd0, 6'd0);
      queue_req(ACT_WR_BYTE, 6'd0, 8'h00, 6'd0);
      // start abandoned by a second start, then a two-byte message
      queue_req(ACT_WR_START, 6'd3, 8'd0, 6'd0);
      queue_req(ACT_WR_BYTE, 6'd0, 8'hA5, 6'd0);
      queue_req(ACT_WR_START, 6'd2, 8'd0, 6'd0);
      queue_req(ACT_WR_BYTE, 6'd0, 8'hFF, 6'd0);
      queue_req(ACT_WR_BYTE, 6'd0, 8'h5A, 6'd0);
      // peek, too-small read, read, discard, then empty again
      queue_req(ACT_PEEK, 6'd0, 8'd0, 6'd63);
      queue_req(ACT_READ, 6'd0, 8'd0, 6'd0);
      queue_req(ACT_READ, 6'd0, 8'd0, 6'd1);
      queue_req(ACT_DISCARD, 6'd0, 8'd0, 6'd0);
      queue_req(ACT_READ, 6'd0, 8'd0, 6'd32);
      wait_quiet();

      for (p = 0; p < PHASE_COUNT; p++) begin
         // idling pattern for this phase
         @(posedge clock);
         case (p % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 63;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 63;
            end
            default: begin
               send_idle_pct  = 24;
               recv_stall_pct = 24;
            end
         endcase
         // capacity write while the block is idle
         @(negedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= capacity_list[p];
         @(negedge clock);
         csr_wr_en   <= 1'b0;
         @(posedge clock);
         queue_random(PHASE_ITEMS);
         wait_quiet();
      end

      if (!fault_seen && due_replies.size() == 0) begin
         $display("** length_prefixed_message_ring: PASSED **");
      end else begin
         $display("** length_prefixed_message_ring: FAILED **");
      end
      $finish;
   end

endmodule
